>>> design/smf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

  // Event kinds carried on the command field.
  typedef enum logic [3:0] {
    CMD_NOTE_ON     = 4'd0,
    CMD_NOTE_OFF    = 4'd1,
    CMD_KEY_PRESS   = 4'd2,
    CMD_CTRL        = 4'd3,
    CMD_PGM         = 4'd4,
    CMD_CHAN_PRESS  = 4'd5,
    CMD_BEND        = 4'd6,
    CMD_CTRL14      = 4'd7,
    CMD_NRPN        = 4'd8,
    CMD_RPN         = 4'd9,
    CMD_SYSEX_START = 4'd10,
    CMD_SYSEX_DATA  = 4'd11,
    CMD_OTHER       = 4'd12
  } cmd_t;

  // Status bytes and controller numbers.
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_KEY_PRESS  = 4'hA;
  localparam logic [3:0] ST_CTRL       = 4'hB;
  localparam logic [3:0] ST_PGM        = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
  localparam logic [3:0] ST_BEND       = 4'hE;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;

  localparam logic [7:0] CC_NRPN_LSB = 8'h62;
  localparam logic [7:0] CC_NRPN_MSB = 8'h63;
  localparam logic [7:0] CC_RPN_LSB  = 8'h64;
  localparam logic [7:0] CC_RPN_MSB  = 8'h65;
  localparam logic [7:0] CC_DATA_MSB = 8'h06;
  localparam logic [7:0] CC_DATA_LSB = 8'h26;
  localparam logic [6:0] CC14_LSB_OFS = 7'h20;

  localparam int MAX_BYTES = 16;

  // One input request as held in the input register.
  typedef struct packed {
    cmd_t               command;
    logic [7:0]         queue_id;
    logic               tick_stamped;
    logic [7:0]         dest_port;
    logic [31:0]        tick;
    logic [3:0]         channel;
    logic [13:0]        param;
    logic signed [14:0] value;
    logic [27:0]        sysex_length;
    logic               sysex_starts_f0;
    logic [7:0]         data_byte;
  } item_t;

  // All bytes caused by one request, first byte in slot 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [4:0]                count;
  } frame_t;

  // A variable-length quantity, most significant group in slot 0.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } vlq_t;

  // Encodes a 28-bit value as one to four variable-length bytes.
  function automatic vlq_t vlq_encode(input logic [27:0] v);
    vlq_t r;
    r.bytes = '0;
    if (v[27:21] != 7'd0) begin
      r.len = 3'd4;
      r.bytes[0] = {1'b1, v[27:21]};
      r.bytes[1] = {1'b1, v[20:14]};
      r.bytes[2] = {1'b1, v[13:7]};
      r.bytes[3] = {1'b0, v[6:0]};
    end else if (v[20:14] != 7'd0) begin
      r.len = 3'd3;
      r.bytes[0] = {1'b1, v[20:14]};
      r.bytes[1] = {1'b1, v[13:7]};
      r.bytes[2] = {1'b0, v[6:0]};
    end else if (v[13:7] != 7'd0) begin
      r.len = 3'd2;
      r.bytes[0] = {1'b1, v[13:7]};
      r.bytes[1] = {1'b0, v[6:0]};
    end else begin
      r.len = 3'd1;
      r.bytes[0] = {1'b0, v[6:0]};
    end
    return r;
  endfunction

  // Status byte of a channel message.
  function automatic logic [7:0] chan_status(input cmd_t cmd, input logic [3:0] ch);
    logic [3:0] hi;
    case (cmd)
      CMD_NOTE_ON:    hi = ST_NOTE_ON;
      CMD_NOTE_OFF:   hi = ST_NOTE_OFF;
      CMD_KEY_PRESS:  hi = ST_KEY_PRESS;
      CMD_PGM:        hi = ST_PGM;
      CMD_CHAN_PRESS: hi = ST_CHAN_PRESS;
      CMD_BEND:       hi = ST_BEND;
      default:        hi = ST_CTRL;
    endcase
    return {hi, ch};
  endfunction

endpackage

`default_nettype wire

>>> design/smf_enc.sv
`timescale 1ns / 1ps
`default_nettype none

module smf_enc (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire smf_pkg::item_t item,
  input  wire logic [7:0]     own_queue,
  output smf_pkg::frame_t     frame
);

  // Track state. The base is start tick plus previous relative tick,
  // which equals the absolute tick of the last emitted event (the start tick before one).
  logic [31:0] base_r, base_nxt;
  logic        start_valid_r, start_valid_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [27:0] rem_r, rem_nxt;

  logic [31:0]       base_eff;
  logic [31:0]       diff;
  logic [27:0]       dsat;
  smf_pkg::vlq_t     dv;
  smf_pkg::vlq_t     lv;
  logic [7:0]        st;
  logic              recorded;
  logic              is_sx_start;
  logic              is_sx_data;
  logic              has_event;
  logic              emits;
  logic              spres;
  logic [6:0]        p7;
  logic [6:0]        v7;
  logic [6:0]        vhi;
  logic [10:0][7:0]  tail;
  logic [3:0]        tlen;
  logic [2:0]        hlen;
  logic [smf_pkg::MAX_BYTES-1:0][7:0] bytes;

  // Delta time, clamped at zero and saturated to 28 bits.
  always_comb begin
    base_eff = start_valid_r ? base_r : item.tick;
    diff     = item.tick - base_eff;
    if (diff[31]) begin
      dsat = '0;
    end else if (diff[30:28] != 3'd0) begin
      dsat = '1;
    end else begin
      dsat = diff[27:0];
    end
    dv = smf_pkg::vlq_encode(dsat);
    lv = smf_pkg::vlq_encode(item.sysex_length);
  end

  // Filtering and status selection.
  always_comb begin
    is_sx_start = (item.command == smf_pkg::CMD_SYSEX_START);
    is_sx_data  = (item.command == smf_pkg::CMD_SYSEX_DATA);
    recorded    = (item.queue_id == own_queue) && item.tick_stamped;
    if (is_sx_start) begin
      st = item.sysex_starts_f0 ? smf_pkg::ST_SYSEX : smf_pkg::ST_SYSEX_ESC;
    end else begin
      st = smf_pkg::chan_status(item.command, item.channel);
    end
    spres = (st != rs_r);
    p7    = item.param[6:0];
    v7    = item.value[6:0];
    vhi   = item.value[13:7];
  end

  // Message bytes that follow the delta and the status.
  always_comb begin
    tail      = '0;
    tlen      = 4'd0;
    has_event = 1'b1;
    case (item.command)
      smf_pkg::CMD_NOTE_ON, smf_pkg::CMD_NOTE_OFF,
      smf_pkg::CMD_KEY_PRESS, smf_pkg::CMD_CTRL: begin
        tail[0] = {1'b0, p7};
        tail[1] = {1'b0, v7};
        tlen    = 4'd2;
      end
      smf_pkg::CMD_PGM, smf_pkg::CMD_CHAN_PRESS: begin
        tail[0] = {1'b0, v7};
        tlen    = 4'd1;
      end
      smf_pkg::CMD_BEND: begin
        // Adding 8192 to a 14-bit value flips its top bit.
        tail[0] = {1'b0, item.value[6:0]};
        tail[1] = {1'b0, ~item.value[13], item.value[12:7]};
        tlen    = 4'd2;
      end
      smf_pkg::CMD_CTRL14: begin
        tail[0] = {1'b0, p7};
        tail[1] = {1'b0, vhi};
        tlen    = 4'd2;
        if (p7 < smf_pkg::CC14_LSB_OFS) begin
          tail[2] = 8'h00;
          tail[3] = {1'b0, p7 + smf_pkg::CC14_LSB_OFS};
          tail[4] = {1'b0, v7};
          tlen    = 4'd5;
        end
      end
      smf_pkg::CMD_NRPN, smf_pkg::CMD_RPN: begin
        tail[0]  = (item.command == smf_pkg::CMD_NRPN) ? smf_pkg::CC_NRPN_LSB
                                                       : smf_pkg::CC_RPN_LSB;
        tail[1]  = {1'b0, p7};
        tail[2]  = 8'h00;
        tail[3]  = (item.command == smf_pkg::CMD_NRPN) ? smf_pkg::CC_NRPN_MSB
                                                       : smf_pkg::CC_RPN_MSB;
        tail[4]  = {1'b0, item.param[13:7]};
        tail[5]  = 8'h00;
        tail[6]  = smf_pkg::CC_DATA_MSB;
        tail[7]  = {1'b0, vhi};
        tail[8]  = 8'h00;
        tail[9]  = smf_pkg::CC_DATA_LSB;
        tail[10] = {1'b0, v7};
        tlen     = 4'd11;
      end
      smf_pkg::CMD_SYSEX_START: begin
        tail[3:0] = lv.bytes;
        tlen      = {1'b0, lv.len};
        has_event = (item.sysex_length != 28'd0);
      end
      default: begin
        has_event = 1'b0;
      end
    endcase
    emits = recorded && (item.dest_port == 8'd0) && has_event && !is_sx_data;
  end

  // Pack delta, optional status and message bytes into one frame, or a lone sysex data byte.
  always_comb begin
    hlen  = dv.len + {2'b00, spres};
    bytes = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < dv.len) begin
        bytes[i] = dv.bytes[i];
      end
    end
    if (spres) begin
      bytes[{1'b0, dv.len}] = st;
    end
    for (int j = 0; j < 11; j++) begin
      if (4'(j) < tlen) begin
        bytes[4'(j) + {1'b0, hlen}] = tail[j];
      end
    end
    if (is_sx_data) begin
      frame.bytes    = '0;
      frame.bytes[0] = item.data_byte;
      frame.count    = {4'd0, rem_r != 28'd0};
    end else if (emits) begin
      frame.bytes = bytes;
      frame.count = {2'b00, hlen} + {1'b0, tlen};
    end else begin
      frame.bytes = bytes;
      frame.count = 5'd0;
    end
  end

  // State update as the request moves into the serializer.
  always_comb begin
    base_nxt        = base_r;
    start_valid_nxt = start_valid_r;
    rs_nxt          = rs_r;
    rem_nxt         = rem_r;
    if (load) begin
      if (is_sx_data) begin
        if (rem_r != 28'd0) begin
          rem_nxt = rem_r - 28'd1;
        end
      end else begin
        rem_nxt = (emits && is_sx_start) ? item.sysex_length : 28'd0;
        if (recorded && !start_valid_r) begin
          start_valid_nxt = 1'b1;
          base_nxt        = item.tick;
        end
        if (emits) begin
          base_nxt = item.tick;
          rs_nxt   = is_sx_start ? 8'h00 : st;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r        <= '0;
      start_valid_r <= 1'b0;
      rs_r          <= '0;
      rem_r         <= '0;
    end else begin
      base_r        <= base_nxt;
      start_valid_r <= start_valid_nxt;
      rs_r          <= rs_nxt;
      rem_r         <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/smf_ser.sv
`timescale 1ns / 1ps
`default_nettype none

module smf_ser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire smf_pkg::frame_t frame,
  output logic                 ready,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  logic [smf_pkg::MAX_BYTES-1:0][7:0] buf_r, buf_nxt;
  logic [4:0]                         left_r, left_nxt;

  // The buffer takes a new frame once its last byte leaves.
  assign out_valid = (left_r != 5'd0);
  assign out_last  = (left_r == 5'd1);
  assign out_byte  = buf_r[0];
  assign ready     = (left_r == 5'd0) || ((left_r == 5'd1) && !out_stall);

  // Shift one byte out for every request taken downstream.
  always_comb begin
    buf_nxt  = buf_r;
    left_nxt = left_r;
    if (load) begin
      buf_nxt  = frame.bytes;
      left_nxt = frame.count;
    end else if (out_valid && !out_stall) begin
      buf_nxt  = {8'h00, buf_r[smf_pkg::MAX_BYTES-1:1]};
      left_nxt = left_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/midi_event_to_smf_track_bytes.sv
// An accepted request passes through the input register and the output shift
// buffer before its first byte leaves. Throughput: one output byte per cycle
// while out_stall is low; a request has up to sixteen bytes, or none.
// The output shift buffer sets the rate; the next request waits in the
// input register meanwhile. Reset (rst_n low, synchronous) clears the
// queue register, the tick base, running status and sysex count.
`timescale 1ns / 1ps
`default_nettype none

module midi_event_to_smf_track_bytes (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_command,
  input  wire logic [7:0]         in_queue_id,
  input  wire logic               in_tick_stamped,
  input  wire logic [7:0]         in_dest_port,
  input  wire logic [31:0]        in_tick,
  input  wire logic [3:0]         in_channel,
  input  wire logic [13:0]        in_param,
  input  wire logic signed [14:0] in_value,
  input  wire logic [27:0]        in_sysex_length,
  input  wire logic               in_sysex_starts_f0,
  input  wire logic [7:0]         in_data_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_last
);

  logic [7:0]      own_queue_r;
  logic            ir_valid_r, ir_valid_nxt;
  smf_pkg::item_t  item_r;
  smf_pkg::frame_t frame;
  logic            ser_ready;
  logic            xfer;
  logic            accept;

  // Queue id register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_queue_r <= '0;
    end else if (cfg_wr_en) begin
      own_queue_r <= cfg_wr_data;
    end
  end

  // Input register handshake.
  assign xfer     = ir_valid_r && ser_ready;
  assign in_stall = ir_valid_r && !xfer;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ir_valid_nxt = ir_valid_r;
    if (accept) begin
      ir_valid_nxt = 1'b1;
    end else if (xfer) begin
      ir_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else begin
      ir_valid_r <= ir_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.command         <= smf_pkg::cmd_t'(in_command);
      item_r.queue_id        <= in_queue_id;
      item_r.tick_stamped    <= in_tick_stamped;
      item_r.dest_port       <= in_dest_port;
      item_r.tick            <= in_tick;
      item_r.channel         <= in_channel;
      item_r.param           <= in_param;
      item_r.value           <= in_value;
      item_r.sysex_length    <= in_sysex_length;
      item_r.sysex_starts_f0 <= in_sysex_starts_f0;
      item_r.data_byte       <= in_data_byte;
    end
  end

  // Event encoding and track state.
  smf_enc u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (xfer),
    .item      (item_r),
    .own_queue (own_queue_r),
    .frame     (frame)
  );

  // Byte serializer and output register.
  smf_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (xfer),
    .frame     (frame),
    .ready     (ser_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import smf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 320;
  localparam int DRAIN_CYCLES = 8;
  localparam int CFG_PERIOD = 80;
  localparam logic [31:0] DELTA_SAT = 32'h0FFF_FFFF;
  localparam logic [7:0] STATUS_NONE = 8'h00;

  // One byte of track data as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } track_byte_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_command = '0;
  logic [7:0] in_queue_id = '0;
  logic in_tick_stamped = 1'b0;
  logic [7:0] in_dest_port = '0;
  logic [31:0] in_tick = '0;
  logic [3:0] in_channel = '0;
  logic [13:0] in_param = '0;
  logic signed [14:0] in_value = '0;
  logic [27:0] in_sysex_length = '0;
  logic in_sysex_starts_f0 = 1'b0;
  logic [7:0] in_data_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic out_last;

  midi_event_to_smf_track_bytes u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_queue_id       (in_queue_id),
    .in_tick_stamped   (in_tick_stamped),
    .in_dest_port      (in_dest_port),
    .in_tick           (in_tick),
    .in_channel        (in_channel),
    .in_param          (in_param),
    .in_value          (in_value),
    .in_sysex_length   (in_sysex_length),
    .in_sysex_starts_f0(in_sysex_starts_f0),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last          (out_last)
  );

  // Encoder state as the testbench tracks it.
  logic [7:0] rec_queue = '0;
  logic [31:0] tick_base = '0;
  logic tick_base_set = 1'b0;
  logic [31:0] last_rel_tick = '0;
  logic [7:0] running_st = STATUS_NONE;
  logic [27:0] sysex_pending = '0;

  logic [7:0] staged[$];
  track_byte_t track_bytes_due[$];
  track_byte_t head_due;

  logic [31:0] stim_tick = '0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  bit long_hold_req = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Byte staging for one request; the block never emits more than MAX_BYTES.
  function automatic void put_byte(input logic [7:0] b);
    if (staged.size() < MAX_BYTES) staged.push_back(b);
  endfunction

  // Variable-length quantity, seven bits per byte, most significant first.
  function automatic void put_vlq(input logic [27:0] v);
    if (v[27:21] != 7'd0) put_byte({1'b1, v[27:21]});
    if (v[27:14] != 14'd0) put_byte({1'b1, v[20:14]});
    if (v[27:7] != 21'd0) put_byte({1'b1, v[13:7]});
    put_byte({1'b0, v[6:0]});
  endfunction

  // Delta from the previous event, clamped at zero and saturated at 28 bits.
  function automatic void put_delta(input logic [31:0] t);
    logic [31:0] rel;
    logic [31:0] d;
    rel = t - tick_base;
    d = rel - last_rel_tick;
    if (d[31]) d = '0;
    else if (d > DELTA_SAT) d = DELTA_SAT;
    put_vlq(d[27:0]);
    last_rel_tick = rel;
  endfunction

  // System status bytes cancel running status instead of setting it.
  function automatic void put_status(input logic [7:0] st);
    if (st != running_st) put_byte(st);
    running_st = (st < ST_SYSEX) ? st : STATUS_NONE;
  endfunction

  // A follow-on controller message that reuses the running status.
  function automatic void put_ctl(input logic [31:0] t, input logic [7:0] num,
                                  input logic [6:0] v);
    put_delta(t);
    put_byte(num);
    put_byte({1'b0, v});
  endfunction

  // Works out the track bytes of one accepted request and queues them.
  function automatic void encode_event(input item_t r);
    logic [6:0] p7;
    logic [6:0] vhi;
    logic [14:0] raw;
    logic [14:0] bend;
    logic [3:0] hi;
    raw = r.value;
    p7 = r.param[6:0];
    vhi = raw[13:7];
    staged.delete();
    if (r.command == CMD_SYSEX_DATA) begin
      if (sysex_pending != '0) begin
        put_byte(r.data_byte);
        sysex_pending = sysex_pending - 28'd1;
      end
    end else begin
      sysex_pending = '0;
      if (r.queue_id == rec_queue && r.tick_stamped) begin
        if (!tick_base_set) begin
          tick_base = r.tick;
          tick_base_set = 1'b1;
        end
        if (r.dest_port == 8'd0) begin
          case (r.command)
            CMD_NOTE_ON, CMD_NOTE_OFF, CMD_KEY_PRESS, CMD_CTRL: begin
              hi = (r.command == CMD_NOTE_ON) ? ST_NOTE_ON :
                   (r.command == CMD_NOTE_OFF) ? ST_NOTE_OFF :
                   (r.command == CMD_KEY_PRESS) ? ST_KEY_PRESS : ST_CTRL;
              put_delta(r.tick);
              put_status({hi, r.channel});
              put_byte({1'b0, p7});
              put_byte({1'b0, raw[6:0]});
            end
            CMD_PGM, CMD_CHAN_PRESS: begin
              hi = (r.command == CMD_PGM) ? ST_PGM : ST_CHAN_PRESS;
              put_delta(r.tick);
              put_status({hi, r.channel});
              put_byte({1'b0, raw[6:0]});
            end
            CMD_BEND: begin
              bend = raw + 15'd8192;
              put_delta(r.tick);
              put_status({ST_BEND, r.channel});
              put_byte({1'b0, bend[6:0]});
              put_byte({1'b0, bend[13:7]});
            end
            CMD_CTRL14: begin
              put_delta(r.tick);
              put_status({ST_CTRL, r.channel});
              put_byte({1'b0, p7});
              put_byte({1'b0, vhi});
              if (p7 < CC14_LSB_OFS) put_ctl(r.tick, {1'b0, p7 + CC14_LSB_OFS}, raw[6:0]);
            end
            CMD_NRPN, CMD_RPN: begin
              put_delta(r.tick);
              put_status({ST_CTRL, r.channel});
              put_byte((r.command == CMD_NRPN) ? CC_NRPN_LSB : CC_RPN_LSB);
              put_byte({1'b0, p7});
              put_ctl(r.tick, (r.command == CMD_NRPN) ? CC_NRPN_MSB : CC_RPN_MSB,
                      r.param[13:7]);
              put_ctl(r.tick, CC_DATA_MSB, vhi);
              put_ctl(r.tick, CC_DATA_LSB, raw[6:0]);
            end
            CMD_SYSEX_START: begin
              if (r.sysex_length != '0) begin
                put_delta(r.tick);
                put_status(r.sysex_starts_f0 ? ST_SYSEX : ST_SYSEX_ESC);
                put_vlq(r.sysex_length);
                sysex_pending = r.sysex_length;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
    for (int k = 0; k < staged.size(); k++) begin
      track_bytes_due.push_back('{data: staged[k], last: (k == staged.size() - 1)});
    end
  endfunction

  // Builds a recordable event at the current stimulus tick.
  function automatic item_t ev(input cmd_t c, input logic [3:0] ch, input logic [13:0] p,
                               input logic signed [14:0] v);
    item_t r;
    r = '0;
    r.command = c;
    r.queue_id = rec_queue;
    r.tick_stamped = 1'b1;
    r.tick = stim_tick;
    r.channel = ch;
    r.param = p;
    r.value = v;
    return r;
  endfunction

  // Random event, mostly recordable, with the tick moving mostly forward.
  function automatic item_t random_event();
    item_t r;
    int sel;
    if ($urandom_range(0, 11) == 0) r.command = cmd_t'($urandom_range(11, 15));
    else r.command = cmd_t'($urandom_range(0, 9));
    r.queue_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : rec_queue;
    r.tick_stamped = ($urandom_range(0, 19) != 0);
    r.dest_port = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    sel = $urandom_range(0, 19);
    if (sel < 12) stim_tick = stim_tick + $urandom_range(0, 300);
    else if (sel < 15) stim_tick = stim_tick;
    else if (sel < 17) stim_tick = stim_tick + ($urandom & 32'h1FFF_FFFF);
    else if (sel < 19) stim_tick = stim_tick - $urandom_range(1, 1000);
    else stim_tick = $urandom;
    r.tick = stim_tick;
    r.channel = 4'($urandom);
    r.param = 14'($urandom);
    r.value = 15'($urandom_range(0, 24575) - 8192);
    r.sysex_length = 28'($urandom);
    r.sysex_starts_f0 = 1'($urandom);
    r.data_byte = 8'($urandom);
    return r;
  endfunction

  // Offers one request and waits until the block takes it.
  task automatic send_event(input item_t r);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= r.command;
    in_queue_id <= r.queue_id;
    in_tick_stamped <= r.tick_stamped;
    in_dest_port <= r.dest_port;
    in_tick <= r.tick;
    in_channel <= r.channel;
    in_param <= r.param;
    in_value <= r.value;
    in_sysex_length <= r.sysex_length;
    in_sysex_starts_f0 <= r.sysex_starts_f0;
    in_data_byte <= r.data_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_event(r);
  endtask

  // Queue register writes happen only once the block has gone quiet.
  task automatic set_own_queue(input logic [7:0] q);
    in_valid <= 1'b0;
    while (track_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= q;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rec_queue = q;
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatches < 10) $display("tb_top: mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Every status kind, delta sizes at the VLQ boundaries, filtering and clamping.
  task automatic test_channel_messages();
    item_t r;
    stim_tick = 32'd1000;
    send_event(ev(CMD_NOTE_ON, 4'd0, 14'd0, 15'sd0));
    stim_tick = stim_tick + 32'd127;
    send_event(ev(CMD_NOTE_ON, 4'd0, 14'h3FFF, 15'sd16383));
    stim_tick = stim_tick + 32'd128;
    send_event(ev(CMD_NOTE_OFF, 4'd15, 14'h3FFF, 15'sd16383));
    stim_tick = stim_tick + 32'd16384;
    send_event(ev(CMD_KEY_PRESS, 4'd3, 14'h2A55, 15'sd100));
    stim_tick = stim_tick + 32'd2097152;
    send_event(ev(CMD_CTRL, 4'd3, 14'd7, 15'sd127));
    send_event(ev(CMD_PGM, 4'd9, 14'd0, -15'sd1));
    send_event(ev(CMD_CHAN_PRESS, 4'd9, 14'd0, 15'sd64));
    send_event(ev(CMD_BEND, 4'd14, 14'd0, -15'sd8192));
    send_event(ev(CMD_BEND, 4'd14, 14'd0, 15'sd16383));
    stim_tick = stim_tick + 32'd10;
    send_event(ev(CMD_OTHER, 4'd1, 14'd5, 15'sd5));
    // Dropped events: wrong queue, no timestamp, nonzero port.
    r = ev(CMD_NOTE_ON, 4'd2, 14'd60, 15'sd90);
    r.queue_id = rec_queue + 8'd1;
    send_event(r);
    r.queue_id = rec_queue;
    r.tick_stamped = 1'b0;
    send_event(r);
    r.tick_stamped = 1'b1;
    r.dest_port = 8'hFF;
    send_event(r);
    // A tick before the base clamps to zero; a huge jump saturates.
    stim_tick = 32'd0;
    send_event(ev(CMD_NOTE_ON, 4'd4, 14'd1, 15'sd1));
    stim_tick = 32'h4000_0000;
    send_event(ev(CMD_NOTE_OFF, 4'd4, 14'd1, 15'sd1));
  endtask

  // 14-bit controllers with and without the LSB message, NRPN and RPN.
  task automatic test_controller_pairs();
    stim_tick = stim_tick + 32'd3;
    send_event(ev(CMD_CTRL14, 4'd5, 14'h3F9F, -15'sd1));
    stim_tick = stim_tick + 32'd200;
    send_event(ev(CMD_CTRL14, 4'd5, 14'h0020, 15'sd12345));
    send_event(ev(CMD_NRPN, 4'd6, 14'h3FFF, 15'sd16383));
    stim_tick = stim_tick + 32'd1;
    send_event(ev(CMD_RPN, 4'd7, 14'd0, -15'sd8192));
  endtask

  // Sysex framing: data bytes, extra data, empty sysex, interruption.
  task automatic test_sysex();
    item_t r;
    stim_tick = stim_tick + 32'd50;
    r = ev(CMD_SYSEX_START, 4'd0, 14'd0, 15'sd0);
    r.sysex_length = 28'd2;
    r.sysex_starts_f0 = 1'b1;
    send_event(r);
    // Data requests ignore every field but the byte itself.
    r = ev(CMD_SYSEX_DATA, 4'd0, 14'd0, 15'sd0);
    r.queue_id = ~rec_queue;
    r.dest_port = 8'hFF;
    r.data_byte = 8'h00;
    send_event(r);
    r.data_byte = 8'hFF;
    send_event(r);
    send_event(r);
    r = ev(CMD_SYSEX_START, 4'd0, 14'd0, 15'sd0);
    r.sysex_length = '0;
    send_event(r);
    stim_tick = stim_tick + 32'd9000;
    r = ev(CMD_SYSEX_START, 4'd0, 14'd0, 15'sd0);
    r.sysex_length = 28'hFFF_FFFF;
    send_event(r);
    r = ev(CMD_SYSEX_DATA, 4'd0, 14'd0, 15'sd0);
    r.data_byte = 8'hA5;
    send_event(r);
    send_event(ev(CMD_NOTE_ON, 4'd8, 14'd64, 15'sd64));
    send_event(r);
  endtask

  // Only events on the configured queue are recorded.
  task automatic test_queue_filter();
    item_t r;
    set_own_queue(8'hFF);
    stim_tick = stim_tick + 32'd17;
    send_event(ev(CMD_NOTE_ON, 4'd1, 14'd40, 15'sd40));
    r = ev(CMD_NOTE_OFF, 4'd1, 14'd40, 15'sd0);
    r.queue_id = 8'h00;
    send_event(r);
    set_own_queue(8'h5A);
    r.queue_id = 8'hFF;
    send_event(r);
    send_event(ev(CMD_NOTE_OFF, 4'd1, 14'd40, 15'sd0));
    set_own_queue(8'h00);
    send_event(ev(CMD_CTRL, 4'd2, 14'd10, 15'sd3));
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    for (int k = 0; k < 24; k++) begin
      stim_tick = stim_tick + 32'd4;
      send_event(ev(CMD_NRPN, 4'(k), 14'($urandom), 15'($urandom)));
    end
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed traffic with some noise, queue changes between phases.
  task automatic test_random_traffic();
    item_t r;
    int made;
    int next_cfg;
    int n;
    logic [27:0] len;
    made = 0;
    next_cfg = CFG_PERIOD;
    while (made < RANDOM_ITEMS) begin
      if (made >= RANDOM_ITEMS * 4 / 5) begin
        gaps_on = 1'b0;
        stall_on = 1'b0;
      end
      if (made >= next_cfg) begin
        case ($urandom_range(0, 2))
          0: set_own_queue(8'h00);
          1: set_own_queue(8'hFF);
          default: set_own_queue(8'($urandom));
        endcase
        next_cfg += CFG_PERIOD;
      end
      if ($urandom_range(0, 7) == 0) begin
        // A sysex transfer, usually complete, sometimes cut short.
        len = ($urandom_range(0, 9) == 0) ? 28'($urandom) : 28'($urandom_range(1, 6));
        n = (len <= 28'd6) ? int'(len) : $urandom_range(1, 6);
        if (n > 1 && $urandom_range(0, 5) == 0) n--;
        r = random_event();
        r.command = CMD_SYSEX_START;
        r.sysex_length = len;
        send_event(r);
        for (int k = 0; k < n; k++) begin
          r = random_event();
          r.command = CMD_SYSEX_DATA;
          send_event(r);
        end
        made += n + 1;
      end else begin
        send_event(random_event());
        made++;
      end
    end
  endtask

  // Receiver stalls: random short bursts, or one long hold on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Each accepted byte is checked against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (track_bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, out_last));
      end else begin
        head_due = track_bytes_due.pop_front();
        if (out_byte !== head_due.data)
          flag_mismatch($sformatf("byte expected %02h got %02h", head_due.data, out_byte));
        if (out_last !== head_due.last)
          flag_mismatch($sformatf("last expected %0b got %0b", head_due.last, out_last));
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_channel_messages();
    test_controller_pairs();
    test_sysex();
    test_queue_filter();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    gaps_on = 1'b0;
    stall_on = 1'b0;
    while (track_bytes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
